[rtl/core/toy_register_machine_execute_top_assert.svh]
// Assertion macros used by the checker module of the execute block.
`ifndef TOY_REGISTER_MACHINE_EXECUTE_TOP_ASSERT_SVH
`define TOY_REGISTER_MACHINE_EXECUTE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TRMX_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("execute block check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define TRMX_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("execute block check failed");

`endif

[rtl/core/trmx_pkg.sv]
// Package with widths, defaults and codes of the toy register machine execute block.
`timescale 1ns / 1ps
package trmx_pkg;

  localparam int PROG_LINES_DEF = 256;
  localparam int MEM_DEPTH_DEF  = 128;
  localparam int NUM_REGS_DEF   = 5;

  localparam int MODE_W = 5;
  localparam int RIDX_W = 3;
  localparam int WORD_W = 32;
  localparam int ADDR_W = 7;
  localparam int LINE_W = 12;
  localparam int PC_W   = 8;
  localparam int ERR_W  = 2;
  localparam int TAG_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_MOV_RR  = 5'd0,
    MODE_MOV_RI  = 5'd1,
    MODE_MOV_MR  = 5'd2,
    MODE_MOV_RM  = 5'd3,
    MODE_MOV_MI  = 5'd4,
    MODE_ADD_R   = 5'd5,
    MODE_ADD_I   = 5'd6,
    MODE_ADD_M   = 5'd7,
    MODE_SUB_R   = 5'd8,
    MODE_SUB_I   = 5'd9,
    MODE_SUB_M   = 5'd10,
    MODE_JMP_Z   = 5'd11,
    MODE_JMP     = 5'd12,
    MODE_JPN     = 5'd13,
    MODE_PRN_R   = 5'd14,
    MODE_PRN_I   = 5'd15,
    MODE_PRN_M   = 5'd16,
    MODE_HLT     = 5'd17
  } mode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_JUMP  = 2'd1,
    ERR_STORE = 2'd2
  } err_t;

  typedef enum logic [TAG_W-1:0] {
    TAG_REG   = 2'd0,
    TAG_CONST = 2'd1,
    TAG_MEM   = 2'd2
  } tag_t;

endpackage

[rtl/core/trmx_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module trmx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/toy_register_machine_execute_top.sv]
// Top level of the toy register machine execute block.
`timescale 1ns / 1ps
// Executes one decoded instruction per input beat and returns one result beat for it.
// Input channel in_*: mode, register operands, constant, data address and jump line.
// Output channel out_*: next program counter, halt flag, error code and print fields.
// Both channels use valid/ready; a beat moves when valid and ready are both high.
// A result passes from the execute stage registers into the output register.
// After the clearing pass, one instruction is taken per cycle while the receiver does not
// stall. The register file and data memory are read when the beat is taken, and written
// back when the instruction leaves the execute stage; a write-back in the cycle that a
// new beat is taken is forwarded to it. Reset clears registers, program counter and
// halt flag at once, then a clearing pass writes zero to every data memory word with in_ready low.
// When the receiver stalls, the result holds in the output register, the execute stage
// holds behind it, and in_ready drops only once both are full.
// After HLT, an error or an undefined mode, later beats return the held counter with
// out_halted set.
module toy_register_machine_execute_top #(
  parameter int PROG_LINES = trmx_pkg::PROG_LINES_DEF,
  parameter int MEM_DEPTH  = trmx_pkg::MEM_DEPTH_DEF,
  parameter int NUM_REGS   = trmx_pkg::NUM_REGS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic        [trmx_pkg::MODE_W-1:0] in_mode,
  input  logic        [trmx_pkg::RIDX_W-1:0] in_first_reg,
  input  logic        [trmx_pkg::RIDX_W-1:0] in_second_reg,
  input  logic signed [trmx_pkg::WORD_W-1:0] in_immediate,
  input  logic        [trmx_pkg::ADDR_W-1:0] in_mem_address,
  input  logic        [trmx_pkg::LINE_W-1:0] in_jump_line,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [trmx_pkg::PC_W-1:0]   out_next_pc,
  output logic                               out_halted,
  output logic        [trmx_pkg::ERR_W-1:0]  out_error_code,
  output logic                               out_print_valid,
  output logic        [trmx_pkg::TAG_W-1:0]  out_print_tag,
  output logic signed [trmx_pkg::WORD_W-1:0] out_print_value,
  output logic        [trmx_pkg::ADDR_W-1:0] out_print_index
);

  import trmx_pkg::*;

  localparam int MAW = $clog2(MEM_DEPTH);
  localparam int RAW = $clog2(NUM_REGS);

  logic in_fire;
  logic s2_fire;

  logic              clr_busy_r;
  logic [MAW-1:0]    clr_addr_r;

  logic              s2_valid_r;
  logic [MODE_W-1:0] s2_mode_r;
  logic [RIDX_W-1:0] s2_ra_r;
  logic [RIDX_W-1:0] s2_rb_r;
  logic [WORD_W-1:0] s2_imm_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic [LINE_W-1:0] s2_line_r;
  logic              s2_ra_ok_r;
  logic              s2_rb_ok_r;
  logic              s2_addr_ok_r;
  logic              s2_ra_vld_r;
  logic              s2_rb_vld_r;
  logic              s2_fa_r;
  logic              s2_fb_r;
  logic              s2_fm_r;
  logic [WORD_W-1:0] fwd_reg_r;
  logic [WORD_W-1:0] fwd_mem_r;

  logic [PC_W-1:0]   pc_r;
  logic [PC_W-1:0]   pc_nxt;
  logic              stop_r;
  logic              stop_nxt;
  logic [NUM_REGS-1:0] reg_vld_r;

  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  logic [WORD_W-1:0] rd_m;
  logic [WORD_W-1:0] opa;
  logic [WORD_W-1:0] opb;
  logic [WORD_W-1:0] opm;
  logic [WORD_W-1:0] store_val;

  logic              reg_we;
  logic [RIDX_W-1:0] reg_widx;
  logic [WORD_W-1:0] reg_wdata;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;
  logic              take_jump;
  logic              step;
  logic [ERR_W-1:0]  err;
  logic              pv;
  logic [TAG_W-1:0]  ptag;
  logic [WORD_W-1:0] pval;
  logic [ADDR_W-1:0] pidx;

  logic              reg_we_fire;
  logic              mem_we_fire;
  logic              ram_m_we;
  logic [MAW-1:0]    ram_m_waddr;
  logic [WORD_W-1:0] ram_m_wdata;

  logic              out_valid_r;
  logic [PC_W-1:0]   out_pc_r;
  logic              out_halted_r;
  logic [ERR_W-1:0]  out_err_r;
  logic              out_pv_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [WORD_W-1:0] out_val_r;
  logic [ADDR_W-1:0] out_idx_r;

  assign s2_fire  = s2_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!s2_valid_r || s2_fire);
  assign in_fire  = in_valid && in_ready;

  assign reg_we_fire = s2_fire && reg_we;
  assign mem_we_fire = s2_fire && mem_we;

  // Register file: two copies so both operands can be read together.
  trmx_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (reg_we_fire),
    .waddr (RAW'(reg_widx)),
    .wdata (reg_wdata),
    .re    (in_fire),
    .raddr (RAW'(in_first_reg)),
    .rdata (rd_a)
  );

  trmx_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (reg_we_fire),
    .waddr (RAW'(reg_widx)),
    .wdata (reg_wdata),
    .re    (in_fire),
    .raddr (RAW'(in_second_reg)),
    .rdata (rd_b)
  );

  assign ram_m_we    = clr_busy_r || mem_we_fire;
  assign ram_m_waddr = clr_busy_r ? clr_addr_r : MAW'(s2_addr_r);
  assign ram_m_wdata = clr_busy_r ? '0 : mem_wdata;

  trmx_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_dmem (
    .clk   (clk),
    .we    (ram_m_we),
    .waddr (ram_m_waddr),
    .wdata (ram_m_wdata),
    .re    (in_fire),
    .raddr (MAW'(in_mem_address)),
    .rdata (rd_m)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + MAW'(1);
      if (clr_addr_r == MAW'(MEM_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (in_fire) begin
      s2_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_mode_r    <= in_mode;
      s2_ra_r      <= in_first_reg;
      s2_rb_r      <= in_second_reg;
      s2_imm_r     <= in_immediate;
      s2_addr_r    <= in_mem_address;
      s2_line_r    <= in_jump_line;
      s2_ra_ok_r   <= 32'(in_first_reg) < NUM_REGS;
      s2_rb_ok_r   <= 32'(in_second_reg) < NUM_REGS;
      s2_addr_ok_r <= 32'(in_mem_address) < MEM_DEPTH;
      s2_ra_vld_r  <= reg_vld_r[RAW'(in_first_reg)];
      s2_rb_vld_r  <= reg_vld_r[RAW'(in_second_reg)];
      s2_fa_r      <= reg_we_fire && (reg_widx == in_first_reg);
      s2_fb_r      <= reg_we_fire && (reg_widx == in_second_reg);
      s2_fm_r      <= mem_we_fire && (s2_addr_r == in_mem_address);
      fwd_reg_r    <= reg_wdata;
      fwd_mem_r    <= mem_wdata;
    end
  end

  assign opa = !s2_ra_ok_r ? '0 : s2_fa_r ? fwd_reg_r : s2_ra_vld_r ? rd_a : '0;
  assign opb = !s2_rb_ok_r ? '0 : s2_fb_r ? fwd_reg_r : s2_rb_vld_r ? rd_b : '0;
  assign opm = !s2_addr_ok_r ? '0 : s2_fm_r ? fwd_mem_r : rd_m;
  assign store_val = (mode_t'(s2_mode_r) == MODE_MOV_MR) ? opa : s2_imm_r;

  always_comb begin
    reg_we    = 1'b0;
    reg_widx  = s2_ra_r;
    reg_wdata = opa;
    mem_we    = 1'b0;
    mem_wdata = store_val;
    take_jump = 1'b0;
    step      = 1'b1;
    stop_nxt  = stop_r;
    pc_nxt    = pc_r;
    err       = ERR_NONE;
    pv        = 1'b0;
    ptag      = TAG_REG;
    pval      = '0;
    pidx      = '0;
    if (stop_r) begin
      step = 1'b0;
    end else begin
      unique case (mode_t'(s2_mode_r)) inside
        MODE_MOV_RR: begin
          reg_we   = s2_rb_ok_r;
          reg_widx = s2_rb_r;
        end
        MODE_MOV_RI: begin
          reg_we    = s2_ra_ok_r;
          reg_wdata = s2_imm_r;
        end
        MODE_MOV_MR, MODE_MOV_MI: begin
          if (store_val[WORD_W-1]) begin
            err      = ERR_STORE;
            stop_nxt = 1'b1;
            step     = 1'b0;
          end else begin
            mem_we = s2_addr_ok_r;
          end
        end
        MODE_MOV_RM: begin
          reg_we    = s2_ra_ok_r;
          reg_wdata = opm;
        end
        MODE_ADD_R: begin
          reg_we    = s2_ra_ok_r;
          reg_wdata = opa + opb;
        end
        MODE_ADD_I: begin
          reg_we    = s2_ra_ok_r;
          reg_wdata = opa + s2_imm_r;
        end
        MODE_ADD_M: begin
          reg_we    = s2_ra_ok_r;
          reg_wdata = opa + opm;
        end
        MODE_SUB_R: begin
          reg_we    = s2_ra_ok_r;
          reg_wdata = opa - opb;
        end
        MODE_SUB_I: begin
          reg_we    = s2_ra_ok_r;
          reg_wdata = opa - s2_imm_r;
        end
        MODE_SUB_M: begin
          reg_we    = s2_ra_ok_r;
          reg_wdata = opa - opm;
        end
        MODE_JMP_Z: take_jump = (opa == '0);
        MODE_JMP:   take_jump = 1'b1;
        MODE_JPN:   take_jump = (opa == '0) || opa[WORD_W-1];
        MODE_PRN_R: begin
          pv   = 1'b1;
          ptag = TAG_REG;
          pval = opa;
          pidx = ADDR_W'(s2_ra_r);
        end
        MODE_PRN_I: begin
          pv   = 1'b1;
          ptag = TAG_CONST;
          pval = s2_imm_r;
        end
        MODE_PRN_M: begin
          pv   = 1'b1;
          ptag = TAG_MEM;
          pval = opm;
          pidx = s2_addr_r;
        end
        default: begin
          stop_nxt = 1'b1;
          step     = 1'b0;
        end
      endcase
      if (take_jump) begin
        step = 1'b0;
        if (s2_line_r == '0 || 32'(s2_line_r) > PROG_LINES) begin
          err      = ERR_JUMP;
          stop_nxt = 1'b1;
        end else begin
          pc_nxt = PC_W'(s2_line_r - LINE_W'(1));
        end
      end
      if (step) begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      stop_r    <= 1'b0;
      reg_vld_r <= '0;
    end else if (s2_fire) begin
      pc_r   <= pc_nxt;
      stop_r <= stop_nxt;
      if (reg_we) begin
        reg_vld_r[RAW'(reg_widx)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_pc_r     <= pc_nxt;
      out_halted_r <= stop_nxt;
      out_err_r    <= err;
      out_pv_r     <= pv;
      out_tag_r    <= ptag;
      out_val_r    <= pval;
      out_idx_r    <= pidx;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_pc_r;
  assign out_halted      = out_halted_r;
  assign out_error_code  = out_err_r;
  assign out_print_valid = out_pv_r;
  assign out_print_tag   = out_tag_r;
  assign out_print_value = out_val_r;
  assign out_print_index = out_idx_r;

endmodule

[rtl/core/trmx_checker.sv]
// Port-level checker for the toy register machine execute block, with its bind.
`timescale 1ns / 1ps
`include "toy_register_machine_execute_top_assert.svh"
module trmx_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic        [trmx_pkg::PC_W-1:0]   out_next_pc,
  input logic                               out_halted,
  input logic        [trmx_pkg::ERR_W-1:0]  out_error_code,
  input logic                               out_print_valid,
  input logic        [trmx_pkg::TAG_W-1:0]  out_print_tag,
  input logic signed [trmx_pkg::WORD_W-1:0] out_print_value,
  input logic        [trmx_pkg::ADDR_W-1:0] out_print_index
);

  import trmx_pkg::*;

  logic halt_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_seen_r <= 1'b0;
    end else if (out_valid && out_ready && out_halted) begin
      halt_seen_r <= 1'b1;
    end
  end

  // A stalled result beat keeps its payload.
  `TRMX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_next_pc) && $stable(out_halted) && $stable(out_error_code) && $stable(out_print_valid) && $stable(out_print_tag) && $stable(out_print_value) && $stable(out_print_index))

  // An error always stops the machine, and a print never comes with an error or a halt.
  `TRMX_ASSERT_NOW(a_err_halts, out_valid && (out_error_code != ERR_NONE), out_halted && !out_print_valid)

  `TRMX_ASSERT_NOW(a_print_clean, out_valid && out_print_valid, !out_halted && (out_error_code == ERR_NONE) && (out_print_tag != 2'd3))

  // Once a halted beat has been delivered, every later beat is halted too.
  `TRMX_ASSERT_NOW(a_halt_sticky, out_valid && halt_seen_r, out_halted && (out_error_code == ERR_NONE) && !out_print_valid)

endmodule

bind toy_register_machine_execute_top trmx_checker u_trmx_checker (.*);

[test/toy_register_machine_execute_top_tb.sv]
// Self-checking testbench for the toy register machine execute block.
`timescale 1ns / 1ps
module toy_register_machine_execute_top_tb;
  import trmx_pkg::*;

  localparam int PROG_LINES   = PROG_LINES_DEF;
  localparam int MEM_DEPTH    = MEM_DEPTH_DEF;
  localparam int NUM_REGS     = NUM_REGS_DEF;
  localparam int RANDOM_ITEMS = 1810;
  localparam int HOLD_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [RIDX_W-1:0] first_reg;
    logic [RIDX_W-1:0] second_reg;
    logic [WORD_W-1:0] immediate;
    logic [ADDR_W-1:0] mem_address;
    logic [LINE_W-1:0] jump_line;
  } instr_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              halted;
    err_t              error_code;
    logic              print_valid;
    tag_t              print_tag;
    logic [WORD_W-1:0] print_value;
    logic [ADDR_W-1:0] print_index;
  } exec_result_t;

  typedef struct packed {
    instr_t       it;
    logic         use_typed;
    exec_result_t res;
  } directed_row_t;

  localparam directed_row_t DIRECTED [26] = '{
    '{'{MODE_PRN_R, 3'd0, 3'd0, 32'h0, 7'd0, 12'd0}, 1'b1,
      '{8'd1, 1'b0, ERR_NONE, 1'b1, TAG_REG, 32'h0, 7'd0}},
    '{'{MODE_PRN_M, 3'd0, 3'd0, 32'h0, 7'd127, 12'd0}, 1'b1,
      '{8'd2, 1'b0, ERR_NONE, 1'b1, TAG_MEM, 32'h0, 7'd127}},
    '{'{MODE_PRN_I, 3'd0, 3'd0, 32'h8000_0000, 7'd0, 12'd0}, 1'b1,
      '{8'd3, 1'b0, ERR_NONE, 1'b1, TAG_CONST, 32'h8000_0000, 7'd0}},
    '{'{MODE_PRN_I, 3'd0, 3'd0, 32'h7fff_ffff, 7'd0, 12'd0}, 1'b1,
      '{8'd4, 1'b0, ERR_NONE, 1'b1, TAG_CONST, 32'h7fff_ffff, 7'd0}},
    '{'{MODE_MOV_RI, 3'd0, 3'd0, 32'h7fff_ffff, 7'd0, 12'd0}, 1'b1,
      '{8'd5, 1'b0, ERR_NONE, 1'b0, TAG_REG, 32'h0, 7'd0}},
    '{'{MODE_ADD_I, 3'd0, 3'd0, 32'h1, 7'd0, 12'd0}, 1'b1,
      '{8'd6, 1'b0, ERR_NONE, 1'b0, TAG_REG, 32'h0, 7'd0}},
    '{'{MODE_PRN_R, 3'd0, 3'd0, 32'h0, 7'd0, 12'd0}, 1'b1,
      '{8'd7, 1'b0, ERR_NONE, 1'b1, TAG_REG, 32'h8000_0000, 7'd0}},
    '{'{MODE_MOV_RI, 3'd1, 3'd0, 32'h8000_0000, 7'd0, 12'd0}, 1'b0, '0},
    '{'{MODE_SUB_I, 3'd1, 3'd0, 32'h1, 7'd0, 12'd0}, 1'b0, '0},
    '{'{MODE_MOV_MR, 3'd1, 3'd0, 32'h0, 7'd0, 12'd0}, 1'b0, '0},
    '{'{MODE_JPN, 3'd1, 3'd0, 32'h0, 7'd0, 12'd0}, 1'b0, '0},
    '{'{MODE_MOV_MI, 3'd0, 3'd0, 32'h7fff_ffff, 7'd5, 12'd0}, 1'b0, '0},
    '{'{MODE_MOV_RM, 3'd2, 3'd0, 32'h0, 7'd5, 12'd0}, 1'b0, '0},
    '{'{MODE_ADD_M, 3'd2, 3'd0, 32'h0, 7'd0, 12'd0}, 1'b0, '0},
    '{'{MODE_SUB_M, 3'd3, 3'd0, 32'h0, 7'd5, 12'd0}, 1'b0, '0},
    '{'{MODE_ADD_R, 3'd3, 3'd2, 32'h0, 7'd0, 12'd0}, 1'b0, '0},
    '{'{MODE_SUB_R, 3'd4, 3'd3, 32'h0, 7'd0, 12'd0}, 1'b0, '0},
    '{'{MODE_MOV_RR, 3'd7, 3'd6, 32'h0, 7'd0, 12'd0}, 1'b0, '0},
    '{'{MODE_MOV_RR, 3'd0, 3'd4, 32'h0, 7'd0, 12'd0}, 1'b0, '0},
    '{'{MODE_PRN_R, 3'd7, 3'd0, 32'h0, 7'd0, 12'd0}, 1'b0, '0},
    '{'{MODE_JMP_Z, 3'd5, 3'd0, 32'h0, 7'd0, 12'd256}, 1'b0, '0},
    '{'{MODE_PRN_I, 3'd0, 3'd0, 32'h0, 7'd0, 12'd0}, 1'b0, '0},
    '{'{MODE_JMP_Z, 3'd0, 3'd0, 32'h0, 7'd0, 12'd4095}, 1'b0, '0},
    '{'{MODE_JPN, 3'd0, 3'd0, 32'h0, 7'd0, 12'd1}, 1'b0, '0},
    '{'{MODE_JMP, 3'd0, 3'd0, 32'h0, 7'd0, 12'd100}, 1'b0, '0},
    '{'{MODE_PRN_M, 3'd0, 3'd0, 32'h0, 7'd5, 12'd0}, 1'b0, '0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode;
  logic [RIDX_W-1:0]    in_first_reg;
  logic [RIDX_W-1:0]    in_second_reg;
  logic signed [WORD_W-1:0] in_immediate;
  logic [ADDR_W-1:0]    in_mem_address;
  logic [LINE_W-1:0]    in_jump_line;
  logic                 out_valid;
  logic                 out_ready;
  logic [PC_W-1:0]      out_next_pc;
  logic                 out_halted;
  logic [ERR_W-1:0]     out_error_code;
  logic                 out_print_valid;
  logic [TAG_W-1:0]     out_print_tag;
  logic signed [WORD_W-1:0] out_print_value;
  logic [ADDR_W-1:0]    out_print_index;

  logic [WORD_W-1:0] model_regs [NUM_REGS];
  logic [WORD_W-1:0] model_mem [MEM_DEPTH];
  logic [PC_W-1:0]   model_pc;
  logic              model_stopped;

  exec_result_t expected_results [$];
  int mismatch_count  = 0;
  int results_checked = 0;
  int sent_count      = 0;
  int cycle_count     = 0;
  int idle_pct        = 0;
  int stall_pct       = 0;
  int hold_requests   = 0;
  int holds_served    = 0;
  int hold_left       = 0;
  int halt_kind       = 0;

  toy_register_machine_execute_top #(
    .PROG_LINES(PROG_LINES),
    .MEM_DEPTH (MEM_DEPTH),
    .NUM_REGS  (NUM_REGS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_first_reg   (in_first_reg),
    .in_second_reg  (in_second_reg),
    .in_immediate   (in_immediate),
    .in_mem_address (in_mem_address),
    .in_jump_line   (in_jump_line),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_pc    (out_next_pc),
    .out_halted     (out_halted),
    .out_error_code (out_error_code),
    .out_print_valid(out_print_valid),
    .out_print_tag  (out_print_tag),
    .out_print_value(out_print_value),
    .out_print_index(out_print_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] read_reg(logic [RIDX_W-1:0] idx);
    return (32'(idx) < NUM_REGS) ? model_regs[idx] : '0;
  endfunction

  function automatic void write_reg(logic [RIDX_W-1:0] idx, logic [WORD_W-1:0] v);
    if (32'(idx) < NUM_REGS) model_regs[idx] = v;
  endfunction

  function automatic exec_result_t execute_instr(instr_t it);
    exec_result_t r;
    logic [WORD_W-1:0] a, b, m, v;
    logic step, taken;
    r = '0;
    a = read_reg(it.first_reg);
    b = read_reg(it.second_reg);
    m = (32'(it.mem_address) < MEM_DEPTH) ? model_mem[it.mem_address] : '0;
    if (!model_stopped) begin
      step = 1'b1;
      taken = 1'b0;
      case (it.mode)
        MODE_MOV_RR: write_reg(it.second_reg, a);
        MODE_MOV_RI: write_reg(it.first_reg, it.immediate);
        MODE_MOV_MR, MODE_MOV_MI: begin
          v = (it.mode == MODE_MOV_MR) ? a : it.immediate;
          if (v[WORD_W-1]) begin
            r.error_code = ERR_STORE;
            model_stopped = 1'b1;
            step = 1'b0;
          end else if (32'(it.mem_address) < MEM_DEPTH) begin
            model_mem[it.mem_address] = v;
          end
        end
        MODE_MOV_RM: write_reg(it.first_reg, m);
        MODE_ADD_R: write_reg(it.first_reg, a + b);
        MODE_ADD_I: write_reg(it.first_reg, a + it.immediate);
        MODE_ADD_M: write_reg(it.first_reg, a + m);
        MODE_SUB_R: write_reg(it.first_reg, a - b);
        MODE_SUB_I: write_reg(it.first_reg, a - it.immediate);
        MODE_SUB_M: write_reg(it.first_reg, a - m);
        MODE_JMP_Z: taken = (a == '0);
        MODE_JMP: taken = 1'b1;
        MODE_JPN: taken = (a == '0) || a[WORD_W-1];
        MODE_PRN_R: begin
          r.print_valid = 1'b1;
          r.print_tag = TAG_REG;
          r.print_value = a;
          r.print_index = {4'd0, it.first_reg};
        end
        MODE_PRN_I: begin
          r.print_valid = 1'b1;
          r.print_tag = TAG_CONST;
          r.print_value = it.immediate;
        end
        MODE_PRN_M: begin
          r.print_valid = 1'b1;
          r.print_tag = TAG_MEM;
          r.print_value = m;
          r.print_index = it.mem_address;
        end
        default: begin
          model_stopped = 1'b1;
          step = 1'b0;
        end
      endcase
      if (taken) begin
        step = 1'b0;
        if (it.jump_line == 12'd0 || 32'(it.jump_line) > PROG_LINES) begin
          model_stopped = 1'b1;
          r.error_code = ERR_JUMP;
        end else begin
          model_pc = 8'(it.jump_line - 12'd1);
        end
      end
      if (step) model_pc = model_pc + 8'd1;
    end
    r.next_pc = model_pc;
    r.halted = model_stopped;
    return r;
  endfunction

  function automatic logic [RIDX_W-1:0] pick_reg();
    if ($urandom_range(0, 9) == 0) return 3'($urandom_range(NUM_REGS, 7));
    return 3'($urandom_range(0, NUM_REGS - 1));
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    it.mode = 5'($urandom_range(0, 16));
    it.first_reg = pick_reg();
    it.second_reg = pick_reg();
    case ($urandom_range(0, 3))
      0: it.immediate = 32'($urandom_range(0, 16)) - 32'd8;
      1: it.immediate = $urandom;
      2: case ($urandom_range(0, 3))
        0: it.immediate = 32'h0;
        1: it.immediate = 32'h7fff_ffff;
        2: it.immediate = 32'h8000_0000;
        default: it.immediate = 32'hffff_ffff;
      endcase
      default: it.immediate = 32'($urandom_range(0, 255));
    endcase
    it.mem_address = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 7)) : 7'($urandom);
    it.jump_line = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                               : 12'($urandom_range(1, PROG_LINES));
    return it;
  endfunction

  // Steers a random instruction away from anything that would stop the machine.
  function automatic instr_t keep_running(instr_t it);
    logic [WORD_W-1:0] a;
    logic taken;
    a = read_reg(it.first_reg);
    taken = (it.mode == MODE_JMP) ||
            (it.mode == MODE_JMP_Z && a == '0) ||
            (it.mode == MODE_JPN && (a == '0 || a[WORD_W-1]));
    if (it.mode == MODE_MOV_MR && a[WORD_W-1]) it.mode = MODE_MOV_RM;
    if (it.mode == MODE_MOV_MI) it.immediate[WORD_W-1] = 1'b0;
    if (taken && (it.jump_line == 12'd0 || 32'(it.jump_line) > PROG_LINES))
      it.jump_line = 12'($urandom_range(1, PROG_LINES));
    return it;
  endfunction

  task automatic issue_instr(input instr_t it, input logic use_typed,
                             input exec_result_t typed_res);
    exec_result_t predicted;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(1, 100) <= idle_pct);
    end
    in_valid       <= 1'b1;
    in_mode        <= it.mode;
    in_first_reg   <= it.first_reg;
    in_second_reg  <= it.second_reg;
    in_immediate   <= it.immediate;
    in_mem_address <= it.mem_address;
    in_jump_line   <= it.jump_line;
    do @(posedge clk); while (!in_ready);
    predicted = execute_instr(it);
    expected_results.insert(expected_results.size(), use_typed ? typed_res : predicted);
    sent_count++;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no instruction waiting, next_pc expected none actual %0d",
               out_next_pc);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("next_pc", 32'(want.next_pc), 32'(out_next_pc));
        check_field("halted", 32'(want.halted), 32'(out_halted));
        check_field("error_code", 32'(want.error_code), 32'(out_error_code));
        check_field("print_valid", 32'(want.print_valid), 32'(out_print_valid));
        check_field("print_tag", 32'(want.print_tag), 32'(out_print_tag));
        check_field("print_value", want.print_value, out_print_value);
        check_field("print_index", 32'(want.print_index), 32'(out_print_index));
        results_checked++;
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (stall_pct == 0) || ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    instr_t it;
    logic [LINE_W-1:0] bad_line;
    for (int k = 0; k < NUM_REGS; k++) model_regs[k] = '0;
    for (int k = 0; k < MEM_DEPTH; k++) model_mem[k] = '0;
    model_pc = '0;
    model_stopped = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_mode        <= '0;
    in_first_reg   <= '0;
    in_second_reg  <= '0;
    in_immediate   <= '0;
    in_mem_address <= '0;
    in_jump_line   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[k]) issue_instr(DIRECTED[k].it, DIRECTED[k].use_typed, DIRECTED[k].res);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n * 4 / RANDOM_ITEMS)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      // The sender keeps offering beats during this hold so the pipeline fills.
      if (n == 100) hold_requests++;
      issue_instr(keep_running(random_instr()), 1'b0, '0);
    end

    // The run ends with exactly one way of stopping the machine.
    halt_kind = $urandom_range(0, 5);
    bad_line = ($urandom_range(0, 1) != 0) ? 12'd0 : 12'($urandom_range(PROG_LINES + 1, 4095));
    it = random_instr();
    case (halt_kind)
      0: it.mode = MODE_HLT;
      1: it.mode = 5'($urandom_range(18, 31));
      2: begin
        it.mode = MODE_JMP;
        it.jump_line = bad_line;
      end
      3: begin
        it.mode = ($urandom_range(0, 1) != 0) ? MODE_JMP_Z : MODE_JPN;
        it.first_reg = 3'($urandom_range(NUM_REGS, 7));
        it.jump_line = bad_line;
      end
      4: begin
        it.mode = MODE_MOV_MI;
        it.immediate[WORD_W-1] = 1'b1;
      end
      default: begin
        it.mode = MODE_MOV_RI;
        it.first_reg = 3'($urandom_range(0, NUM_REGS - 1));
        it.immediate[WORD_W-1] = 1'b1;
        issue_instr(it, 1'b0, '0);
        it.mode = MODE_MOV_MR;
      end
    endcase
    issue_instr(it, 1'b0, '0);
    repeat (4) issue_instr(random_instr(), 1'b0, '0);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d result beats from %0d instructions over four handshake mixes",
             results_checked, sent_count);
    $display("and one long output hold; the program was stopped by case %0d.", halt_kind);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[toy_register_machine_execute_top.f]
+incdir+rtl/core
rtl/core/trmx_pkg.sv
rtl/core/trmx_ram.sv
rtl/core/toy_register_machine_execute_top.sv
rtl/core/trmx_checker.sv
test/toy_register_machine_execute_top_tb.sv
